// File: hdl/termcap_escape_decoder_macros.svh
// assertion macros for the termcap escape decoder
// used by the top level only, expects aclk and aresetn in scope
`ifndef TERMCAP_ESCAPE_DECODER_MACROS_SVH
`define TERMCAP_ESCAPE_DECODER_MACROS_SVH

// clocked check, off while reset is active
`define TCESC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("termcap escape decoder check failed");

// clocked check with its own message
`define TCESC_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`endif

// File: hdl/tcesc_pkg.sv
// shared types, character codes and helpers for the termcap escape decoder
// no dependencies
`default_nettype none

package tcesc_pkg;

    typedef enum logic [2:0] {
        PH_SKIP  = 3'd0,
        PH_PLAIN = 3'd1,
        PH_ESC   = 3'd2,
        PH_OCT   = 3'd3,
        PH_CARET = 3'd4
    } phase_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_T = 8'h74;

    localparam logic [7:0] BYTE_ESC = 8'h1B;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    localparam logic [7:0] CARET_OFFSET = 8'h40;
    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } result_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] oval;
        logic [1:0] odig;
    } state_t;

    typedef struct packed {
        logic    wr0;
        logic    wr1;
        result_t res0;
        result_t res1;
    } push_t;

    localparam state_t STATE_RESET = '{phase: PH_SKIP, oval: 8'h00, odig: 2'd0};
    localparam result_t RESULT_END = '{data: 8'h00, valid: 1'b0, last: 1'b1};

    function automatic logic is_term(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_COLON);
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

// File: hdl/tcesc_decode.sv
// one decode step: next state and up to two results for one character
// depends on tcesc_pkg
`default_nettype none

module tcesc_decode (
    input  wire logic [7:0]        in_char,
    input  wire tcesc_pkg::state_t state_cur,
    output tcesc_pkg::state_t      state_nxt,
    output tcesc_pkg::push_t       push
);

    typedef struct packed {
        logic               emit;
        tcesc_pkg::result_t res;
        tcesc_pkg::phase_t  phase;
    } plain_t;

    function automatic plain_t plain_step(input logic [7:0] c);
        plain_t p;
        p.emit  = 1'b1;
        p.res   = '{data: c, valid: 1'b1, last: 1'b0};
        p.phase = tcesc_pkg::PH_PLAIN;
        if (tcesc_pkg::is_term(c)) begin
            p.res   = tcesc_pkg::RESULT_END;
            p.phase = tcesc_pkg::PH_SKIP;
        end else if (c == tcesc_pkg::CH_BSLASH) begin
            p.emit  = 1'b0;
            p.phase = tcesc_pkg::PH_ESC;
        end else if (c == tcesc_pkg::CH_CARET) begin
            p.emit  = 1'b0;
            p.phase = tcesc_pkg::PH_CARET;
        end
        return p;
    endfunction

    plain_t     pl;
    logic [7:0] digit;
    logic [7:0] oct_sum;
    logic [1:0] dig_sum;
    logic [7:0] esc_byte;

    assign pl      = plain_step(in_char);
    assign digit   = in_char - tcesc_pkg::CH_ZERO;
    assign oct_sum = {state_cur.oval[4:0], 3'b000} + digit;
    assign dig_sum = state_cur.odig + 2'd1;

    always_comb begin
        unique case (in_char)
            tcesc_pkg::CH_UPPER_E: esc_byte = tcesc_pkg::BYTE_ESC;
            tcesc_pkg::CH_LOWER_N: esc_byte = tcesc_pkg::BYTE_LF;
            tcesc_pkg::CH_LOWER_R: esc_byte = tcesc_pkg::BYTE_CR;
            tcesc_pkg::CH_LOWER_B: esc_byte = tcesc_pkg::BYTE_BS;
            tcesc_pkg::CH_LOWER_T: esc_byte = tcesc_pkg::BYTE_TAB;
            default:               esc_byte = in_char;
        endcase
    end

    always_comb begin
        state_nxt = state_cur;
        push      = '0;
        unique case (state_cur.phase)
            tcesc_pkg::PH_SKIP: begin
                if (!tcesc_pkg::is_dec(in_char)) begin
                    state_nxt.phase = pl.phase;
                    push.wr0        = pl.emit;
                    push.res0       = pl.res;
                    if (pl.res.last) begin
                        state_nxt = tcesc_pkg::STATE_RESET;
                    end
                end
            end
            tcesc_pkg::PH_ESC: begin
                if (tcesc_pkg::is_term(in_char)) begin
                    state_nxt = tcesc_pkg::STATE_RESET;
                    push.wr0  = 1'b1;
                    push.res0 = tcesc_pkg::RESULT_END;
                end else if (tcesc_pkg::is_dec(in_char)) begin
                    state_nxt.phase = tcesc_pkg::PH_OCT;
                    state_nxt.oval  = digit;
                    state_nxt.odig  = 2'd1;
                end else begin
                    state_nxt.phase = tcesc_pkg::PH_PLAIN;
                    push.wr0        = 1'b1;
                    push.res0       = '{data: esc_byte, valid: 1'b1, last: 1'b0};
                end
            end
            tcesc_pkg::PH_OCT: begin
                if (tcesc_pkg::is_dec(in_char)) begin
                    if (dig_sum == tcesc_pkg::OCT_MAX_DIGITS || dig_sum == 2'd0) begin
                        state_nxt.phase = tcesc_pkg::PH_PLAIN;
                        state_nxt.oval  = 8'h00;
                        state_nxt.odig  = 2'd0;
                        push.wr0        = 1'b1;
                        push.res0       = '{data: oct_sum, valid: 1'b1, last: 1'b0};
                    end else begin
                        state_nxt.oval = oct_sum;
                        state_nxt.odig = dig_sum;
                    end
                end else begin
                    // flush the pending value, then the character as plain text
                    state_nxt.phase = pl.phase;
                    state_nxt.oval  = 8'h00;
                    state_nxt.odig  = 2'd0;
                    push.wr0        = 1'b1;
                    push.res0       = '{data: state_cur.oval, valid: 1'b1, last: 1'b0};
                    push.wr1        = pl.emit;
                    push.res1       = pl.res;
                end
            end
            tcesc_pkg::PH_CARET: begin
                if (tcesc_pkg::is_term(in_char)) begin
                    state_nxt = tcesc_pkg::STATE_RESET;
                    push.wr0  = 1'b1;
                    push.res0 = tcesc_pkg::RESULT_END;
                end else begin
                    state_nxt.phase = tcesc_pkg::PH_PLAIN;
                    push.wr0        = 1'b1;
                    push.res0       = '{data: in_char - tcesc_pkg::CARET_OFFSET,
                                        valid: 1'b1, last: 1'b0};
                end
            end
            default: begin
                state_nxt.phase = pl.phase;
                push.wr0        = pl.emit;
                push.res0       = pl.res;
                if (pl.res.last) begin
                    state_nxt = tcesc_pkg::STATE_RESET;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/tcesc_outq.sv
// small result queue: takes up to two results per cycle, gives one per cycle while popped
// depends on tcesc_pkg
`default_nettype none

module tcesc_outq #(
    parameter int DEPTH = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire tcesc_pkg::push_t            push,
    input  wire logic                        pop,
    output tcesc_pkg::result_t               head,
    output logic                             head_valid,
    output logic                             room,
    output logic [$clog2(DEPTH+1)-1:0]       count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcesc_pkg::result_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next, wptr1;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wptr1 = ptr_inc(wptr_reg);

    always_comb begin
        wptr_next = wptr_reg;
        if (push.wr1) begin
            wptr_next = ptr_inc(wptr1);
        end else if (push.wr0) begin
            wptr_next = wptr1;
        end
        rptr_next  = pop ? ptr_inc(rptr_reg) : rptr_reg;
        count_next = count_reg + CNT_W'(push.wr0) + CNT_W'(push.wr1) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (push.wr0 && wptr_reg == PTR_W'(i)) begin
                entry_reg[i] <= push.res0;
            end else if (push.wr1 && wptr1 == PTR_W'(i)) begin
                entry_reg[i] <= push.res1;
            end
        end
    end

    assign head       = entry_reg[rptr_reg];
    assign head_valid = (count_reg != '0);
    assign room       = (count_reg <= CNT_W'(DEPTH - 2));
    assign count      = count_reg;

endmodule

`default_nettype wire

// File: hdl/termcap_escape_decoder.sv
// termcap escape decoder: input stage register, then decode into the result queue on m_*
// throughput one character per cycle while the queue has room; a flush of a pending octal
// byte gives two results, which leave one at a time and are absorbed by the result queue
// the queue holds 4 results by default; input stalls when fewer than 2 are free
// reset (aresetn low, synchronous) empties input stage and queue, decoder skips digits
// depends on tcesc_pkg, tcesc_decode, tcesc_outq and the macros header
`default_nettype none
`include "termcap_escape_decoder_macros.svh"

module termcap_escape_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_char
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] byte_valid
    output logic            m_tlast
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic               in_valid_reg;
    logic [7:0]         in_char_reg;
    logic               advance;
    logic               term_accept;
    tcesc_pkg::state_t  state_reg, state_next;
    tcesc_pkg::push_t   dec_push, q_push;
    tcesc_pkg::result_t q_head;
    logic               q_room;
    logic [CNT_W-1:0]   q_count;

    assign advance     = in_valid_reg && q_room;
    assign s_tready    = !in_valid_reg || q_room;
    assign term_accept = advance && tcesc_pkg::is_term(in_char_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcesc_pkg::STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    tcesc_decode u_decode (
        .in_char   (in_char_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .push      (dec_push)
    );

    always_comb begin
        q_push     = dec_push;
        q_push.wr0 = dec_push.wr0 && advance;
        q_push.wr1 = dec_push.wr1 && advance;
    end

    tcesc_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .pop        (m_tvalid && m_tready),
        .head       (q_head),
        .head_valid (m_tvalid),
        .room       (q_room),
        .count      (q_count)
    );

    assign m_tdata = q_head.data;
    assign m_tuser = q_head.valid;
    assign m_tlast = q_head.last;

    `TCESC_ASSERT_MSG(a_queue_bound, (q_count <= CNT_W'(QUEUE_DEPTH)), "result queue overrun")
    `TCESC_ASSERT(a_end_is_empty, (m_tvalid && m_tlast) |-> (!m_tuser && m_tdata == 8'h00))
    `TCESC_ASSERT(a_term_resets, term_accept |=> (state_reg == tcesc_pkg::STATE_RESET))
    `TCESC_ASSERT(a_two_needs_one, q_push.wr1 |-> q_push.wr0)

endmodule

`default_nettype wire
